// ===== hw/rtl/dns_name_syntax_checker_unit_assert.svh =====
// Assertion macros shared by the DNS name checker RTL.
`ifndef DNS_NAME_SYNTAX_CHECKER_UNIT_ASSERT_SVH
`define DNS_NAME_SYNTAX_CHECKER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define DNSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define DNSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/dnsc_pkg.sv =====
// Types, constants and helpers of the DNS name checker.
`default_nettype none
package dnsc_pkg;

    localparam int MAX_NAME   = 255;
    localparam int MAX_LABEL  = 63;
    localparam int FIFO_DEPTH = 4;

    localparam int CH_W    = 8;
    localparam int CNT_W   = 9;
    localparam int KINDS_W = 10;
    localparam int PEND_W  = 3;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [CH_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CH_W-1:0] CH_HYPHEN = 8'h2D;
    localparam logic [CH_W-1:0] CH_STAR   = 8'h2A;

    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    // error_kinds bit positions
    localparam int ERR_EMPTY     = 0;
    localparam int ERR_TOO_LONG  = 1;
    localparam int ERR_NOT_ROOT  = 2;
    localparam int ERR_LBL_LONG  = 3;
    localparam int ERR_BLANK     = 4;
    localparam int ERR_LEAD_HYP  = 5;
    localparam int ERR_TRAIL_HYP = 6;
    localparam int ERR_STAR_MIX  = 7;
    localparam int ERR_ILLEGAL   = 8;
    localparam int ERR_WILDCARD  = 9;

    // pending label kinds
    localparam int PK_LEAD = 0;
    localparam int PK_STAR = 1;
    localparam int PK_ILL  = 2;

    typedef struct packed {
        logic            op_end;
        logic            is_dot;
        logic            is_hyphen;
        logic            is_star;
        logic            is_alnum;
        logic            rec;
        logic [CH_W-1:0] ch;
    } t_cls;

    function automatic logic is_alnum(input logic [CH_W-1:0] c);
        logic r;
        r = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A)
            || (c >= 8'h61 && c <= 8'h7A);
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W:0] b);
        logic [CNT_W+1:0] s;
        s = {2'b00, a} + {1'b0, b};
        return (s > {2'b00, CNT_MAX}) ? CNT_MAX : s[CNT_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/dnsc_front.sv =====
// Input side: accepts items and classifies each character.
`default_nettype none
module dnsc_front (
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_op,
    input  wire logic [dnsc_pkg::CH_W-1:0]   i_ch,
    input  wire logic                        i_record_mode,
    input  wire logic                        i_fifo_full,
    output logic                             o_push,
    output dnsc_pkg::t_cls                   o_cls
);

    assign o_in_stall = i_fifo_full;
    assign o_push     = i_in_valid && !i_fifo_full;

    always_comb begin
        o_cls.op_end    = (i_op == dnsc_pkg::OP_END);
        o_cls.is_dot    = (i_ch == dnsc_pkg::CH_DOT);
        o_cls.is_hyphen = (i_ch == dnsc_pkg::CH_HYPHEN);
        o_cls.is_star   = (i_ch == dnsc_pkg::CH_STAR);
        o_cls.is_alnum  = dnsc_pkg::is_alnum(i_ch);
        o_cls.rec       = i_record_mode;
        o_cls.ch        = i_ch;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/dnsc_fifo.sv =====
// Short queue of classified items between front and back.
`default_nettype none
`include "dns_name_syntax_checker_unit_assert.svh"
module dnsc_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire dnsc_pkg::t_cls  i_din,
    input  wire logic            i_pop,
    output dnsc_pkg::t_cls       o_dout,
    output logic                 o_empty,
    output logic                 o_full
);

    localparam int DEPTH = dnsc_pkg::FIFO_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    dnsc_pkg::t_cls  r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            wr;
    logic            rd;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == FULL);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_dout  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_din;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr && !rd) begin
                r_count <= r_count + 1'b1;
            end else if (rd && !wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `DNSC_ASSERT_NOW(a_cnt_range, 1'b1, r_count <= FULL, "queue count beyond depth")
    `DNSC_ASSERT_NOW(a_pop_nonempty, i_pop, !o_empty, "pop from empty queue")
    `DNSC_ASSERT_NEXT(a_full_holds, o_full && !i_pop, o_full, "full queue lost an item")

endmodule
`default_nettype wire

// ===== hw/rtl/dnsc_back.sv =====
// Back end: per-label checks, name verdict and output register.
`default_nettype none
`include "dns_name_syntax_checker_unit_assert.svh"
module dnsc_back (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire dnsc_pkg::t_cls                   i_cls,
    input  wire logic                             i_fifo_empty,
    output logic                                  o_pop,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic [dnsc_pkg::KINDS_W-1:0]          o_error_kinds,
    output logic [dnsc_pkg::CNT_W-1:0]            o_problem_count,
    output logic [dnsc_pkg::CH_W-1:0]             o_first_bad_char,
    output logic                                  o_name_ok
);

    localparam int CNT_W   = dnsc_pkg::CNT_W;
    localparam int CH_W    = dnsc_pkg::CH_W;
    localparam int KINDS_W = dnsc_pkg::KINDS_W;
    localparam int PEND_W  = dnsc_pkg::PEND_W;
    localparam logic [CNT_W-1:0] MAX_NAME_C  = CNT_W'(dnsc_pkg::MAX_NAME);
    localparam logic [CNT_W-1:0] MAX_LABEL_C = CNT_W'(dnsc_pkg::MAX_LABEL);
    localparam logic [CNT_W:0]   ONE         = (CNT_W+1)'(1);

    logic [CNT_W-1:0]   r_name_len,  n_name_len;
    logic [CNT_W-1:0]   r_lbl_len,   n_lbl_len;
    logic               r_lbl_star,  n_lbl_star;
    logic               r_prev_hyp,  n_prev_hyp;
    logic [PEND_W-1:0]  r_pkinds,    n_pkinds;
    logic [CNT_W-1:0]   r_pcount,    n_pcount;
    logic [CH_W-1:0]    r_pbad,      n_pbad;
    logic [KINDS_W-1:0] r_ckinds,    n_ckinds;
    logic [CNT_W-1:0]   r_ccount,    n_ccount;
    logic [CH_W-1:0]    r_cbad,      n_cbad;
    logic               r_first_dot, n_first_dot;

    logic [KINDS_W-1:0] res_kinds;
    logic [CNT_W-1:0]   res_count;
    logic [CH_W-1:0]    res_bad;
    logic               take_end;
    logic [1:0]         lbl_probs;

    assign o_pop    = !i_fifo_empty && (!i_cls.op_end || !o_out_valid || !i_out_stall);
    assign take_end = o_pop && i_cls.op_end;

    always_comb begin
        n_name_len  = r_name_len;
        n_lbl_len   = r_lbl_len;
        n_lbl_star  = r_lbl_star;
        n_prev_hyp  = r_prev_hyp;
        n_pkinds    = r_pkinds;
        n_pcount    = r_pcount;
        n_pbad      = r_pbad;
        n_ckinds    = r_ckinds;
        n_ccount    = r_ccount;
        n_cbad      = r_cbad;
        n_first_dot = r_first_dot;
        res_kinds   = r_ckinds;
        res_count   = r_ccount;
        res_bad     = r_cbad;
        lbl_probs   = 2'(r_lbl_len > MAX_LABEL_C) + 2'(r_lbl_len == '0)
                      + 2'(r_prev_hyp && r_lbl_len != '0);

        if (o_pop && !i_cls.op_end) begin
            if (r_name_len == '0 && i_cls.is_dot) begin
                n_first_dot = 1'b1;
            end
            n_name_len = dnsc_pkg::sat_add(r_name_len, ONE);
            if (i_cls.is_dot) begin
                if (r_lbl_star) begin
                    if (!i_cls.rec) begin
                        n_ckinds[dnsc_pkg::ERR_WILDCARD] = 1'b1;
                        n_ccount = dnsc_pkg::sat_add(r_ccount, ONE);
                    end
                end else begin
                    if (r_lbl_len > MAX_LABEL_C) begin
                        n_ckinds[dnsc_pkg::ERR_LBL_LONG] = 1'b1;
                    end
                    if (r_lbl_len == '0) begin
                        n_ckinds[dnsc_pkg::ERR_BLANK] = 1'b1;
                    end
                    if (r_prev_hyp && r_lbl_len != '0) begin
                        n_ckinds[dnsc_pkg::ERR_TRAIL_HYP] = 1'b1;
                    end
                    if (r_pkinds[dnsc_pkg::PK_LEAD]) begin
                        n_ckinds[dnsc_pkg::ERR_LEAD_HYP] = 1'b1;
                    end
                    if (r_pkinds[dnsc_pkg::PK_STAR]) begin
                        n_ckinds[dnsc_pkg::ERR_STAR_MIX] = 1'b1;
                    end
                    if (r_pkinds[dnsc_pkg::PK_ILL]) begin
                        if (!r_ckinds[dnsc_pkg::ERR_ILLEGAL]) begin
                            n_cbad = r_pbad;
                        end
                        n_ckinds[dnsc_pkg::ERR_ILLEGAL] = 1'b1;
                    end
                    n_ccount = dnsc_pkg::sat_add(r_ccount,
                                   {1'b0, r_pcount} + (CNT_W+1)'(lbl_probs));
                end
                n_lbl_len  = '0;
                n_lbl_star = 1'b0;
                n_prev_hyp = 1'b0;
                n_pkinds   = '0;
                n_pcount   = '0;
                n_pbad     = '0;
            end else begin
                n_lbl_star = (r_lbl_len == '0) && i_cls.is_star;
                if (i_cls.is_hyphen) begin
                    if (r_lbl_len == '0) begin
                        n_pkinds[dnsc_pkg::PK_LEAD] = 1'b1;
                        n_pcount = dnsc_pkg::sat_add(r_pcount, ONE);
                    end
                end else if (!i_cls.is_alnum) begin
                    if (i_cls.rec && i_cls.is_star) begin
                        n_pkinds[dnsc_pkg::PK_STAR] = 1'b1;
                    end else begin
                        if (!r_pkinds[dnsc_pkg::PK_ILL]) begin
                            n_pbad = i_cls.ch;
                        end
                        n_pkinds[dnsc_pkg::PK_ILL] = 1'b1;
                    end
                    n_pcount = dnsc_pkg::sat_add(r_pcount, ONE);
                end
                n_prev_hyp = i_cls.is_hyphen;
                n_lbl_len  = dnsc_pkg::sat_add(r_lbl_len, ONE);
            end
        end else if (take_end) begin
            if (r_name_len == '0) begin
                res_kinds = KINDS_W'(1) << dnsc_pkg::ERR_EMPTY;
                res_count = CNT_W'(1);
                res_bad   = '0;
            end else if (r_name_len > MAX_NAME_C) begin
                res_kinds = KINDS_W'(1) << dnsc_pkg::ERR_TOO_LONG;
                res_count = CNT_W'(1);
                res_bad   = '0;
            end else if (r_name_len == CNT_W'(1) && r_first_dot) begin
                res_kinds = '0;
                res_count = '0;
                res_bad   = '0;
            end else if (r_lbl_len != '0) begin
                res_kinds[dnsc_pkg::ERR_NOT_ROOT] = 1'b1;
                res_count = dnsc_pkg::sat_add(r_ccount, ONE);
            end
            n_name_len  = '0;
            n_lbl_len   = '0;
            n_lbl_star  = 1'b0;
            n_prev_hyp  = 1'b0;
            n_pkinds    = '0;
            n_pcount    = '0;
            n_pbad      = '0;
            n_ckinds    = '0;
            n_ccount    = '0;
            n_cbad      = '0;
            n_first_dot = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_len  <= '0;
            r_lbl_len   <= '0;
            r_lbl_star  <= 1'b0;
            r_prev_hyp  <= 1'b0;
            r_pkinds    <= '0;
            r_pcount    <= '0;
            r_pbad      <= '0;
            r_ckinds    <= '0;
            r_ccount    <= '0;
            r_cbad      <= '0;
            r_first_dot <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_name_len  <= n_name_len;
            r_lbl_len   <= n_lbl_len;
            r_lbl_star  <= n_lbl_star;
            r_prev_hyp  <= n_prev_hyp;
            r_pkinds    <= n_pkinds;
            r_pcount    <= n_pcount;
            r_pbad      <= n_pbad;
            r_ckinds    <= n_ckinds;
            r_ccount    <= n_ccount;
            r_cbad      <= n_cbad;
            r_first_dot <= n_first_dot;
            if (take_end) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_end) begin
            o_error_kinds    <= res_kinds;
            o_problem_count  <= res_count;
            o_first_bad_char <= res_bad;
            o_name_ok        <= (res_count == '0);
        end
    end

    `DNSC_ASSERT_NOW(a_ok_matches, o_out_valid, o_name_ok == (o_problem_count == '0),
        "name_ok disagrees with problem count")
    `DNSC_ASSERT_NOW(a_bad_needs_ill, o_out_valid && o_first_bad_char != '0,
        o_error_kinds[dnsc_pkg::ERR_ILLEGAL], "bad char without illegal kind")
    `DNSC_ASSERT_NOW(a_empty_alone, o_out_valid && o_error_kinds[dnsc_pkg::ERR_EMPTY],
        o_problem_count == CNT_W'(1) && o_error_kinds == (KINDS_W'(1) << dnsc_pkg::ERR_EMPTY),
        "empty name must report alone")

endmodule
`default_nettype wire

// ===== hw/rtl/dns_name_syntax_checker_unit.sv =====
// Top level of the DNS name syntax checker.
//
// Input channel: one item per character of a fully qualified name (i_op = 0,
// character on i_ch), then one end item (i_op = 1). i_record_mode allows a lone
// wildcard label. An item is taken at a clock edge with i_in_valid high and
// o_in_stall low.
// Output channel: one result per end item on o_error_kinds, o_problem_count,
// o_first_bad_char and o_name_ok, taken at an edge with o_out_valid high and
// i_out_stall low. Character items give no result.
// Throughput: one item per cycle while the queue is not full. Every character
// only updates a few flags and counters in the back end, which retires one
// queued item per cycle, except that an end item waits while a result is held.
// Result path: an accepted end item is written into the queue, then popped by
// the back end into the output register, which raises o_out_valid.
// Stall: while a result waits, character items keep flowing; the next end item
// waits in the four-entry queue, and o_in_stall rises once that queue is full.
// Reset (i_rst_n low, synchronous): queue emptied, name state cleared, no
// result pending.
`default_nettype none
module dns_name_syntax_checker_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_op,
    input  wire logic [dnsc_pkg::CH_W-1:0]         i_ch,
    input  wire logic                              i_record_mode,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [dnsc_pkg::KINDS_W-1:0]           o_error_kinds,
    output logic [dnsc_pkg::CNT_W-1:0]             o_problem_count,
    output logic [dnsc_pkg::CH_W-1:0]              o_first_bad_char,
    output logic                                   o_name_ok
);

    dnsc_pkg::t_cls push_cls;
    dnsc_pkg::t_cls pop_cls;
    logic           push;
    logic           pop;
    logic           fifo_full;
    logic           fifo_empty;

    dnsc_front u_front (
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_ch          (i_ch),
        .i_record_mode (i_record_mode),
        .i_fifo_full   (fifo_full),
        .o_push        (push),
        .o_cls         (push_cls)
    );

    dnsc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_din   (push_cls),
        .i_pop   (pop),
        .o_dout  (pop_cls),
        .o_empty (fifo_empty),
        .o_full  (fifo_full)
    );

    dnsc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cls            (pop_cls),
        .i_fifo_empty     (fifo_empty),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_error_kinds    (o_error_kinds),
        .o_problem_count  (o_problem_count),
        .o_first_bad_char (o_first_bad_char),
        .o_name_ok        (o_name_ok)
    );

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench of dns_name_syntax_checker_unit: directed and random names, predicted verdicts.
module tb;

    localparam int NAME_ITEMS  = 950;
    localparam int IDLE_LIMIT  = 1000;
    localparam int TAIL_CYCLES = 10;

    typedef struct packed {
        logic [dnsc_pkg::KINDS_W-1:0] kinds;
        logic [dnsc_pkg::CNT_W-1:0]   count;
        logic [dnsc_pkg::CH_W-1:0]    bad;
        logic                         ok;
    } t_name_verdict;

    class t_verdict_board;
        t_name_verdict                verdicts_due[$];
        int unsigned                  mismatches;
        int unsigned                  name_chars;
        int unsigned                  label_chars;
        int unsigned                  label_problems;
        int unsigned                  name_problems;
        bit                           lone_star;
        bit                           ended_hyphen;
        bit                           leading_dot;
        bit [dnsc_pkg::PEND_W-1:0]    label_flags;
        bit [dnsc_pkg::CH_W-1:0]      label_bad;
        bit [dnsc_pkg::CH_W-1:0]      name_bad;
        bit [dnsc_pkg::KINDS_W-1:0]   name_kinds;

        function new();
            mismatches = 0;
            clear_name();
        endfunction

        function int unsigned capped(int unsigned a, int unsigned b);
            int unsigned cap;
            cap = int'(dnsc_pkg::CNT_MAX);
            return (a + b > cap) ? cap : a + b;
        endfunction

        function void clear_label();
            label_chars    = 0;
            lone_star      = 0;
            ended_hyphen   = 0;
            label_flags    = '0;
            label_problems = 0;
            label_bad      = '0;
        endfunction

        function void clear_name();
            name_chars    = 0;
            name_kinds    = '0;
            name_problems = 0;
            name_bad      = '0;
            leading_dot   = 0;
            clear_label();
        endfunction

        function void flag(int pos);
            name_kinds[pos] = 1'b1;
            name_problems   = capped(name_problems, 1);
        endfunction

        function bit legal_char(logic [dnsc_pkg::CH_W-1:0] c);
            return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A)
                || (c >= 8'h61 && c <= 8'h7A);
        endfunction

        function void close_label(logic rec);
            if (lone_star) begin
                if (!rec) flag(dnsc_pkg::ERR_WILDCARD);
            end else begin
                if (label_chars > dnsc_pkg::MAX_LABEL) flag(dnsc_pkg::ERR_LBL_LONG);
                if (label_chars == 0) flag(dnsc_pkg::ERR_BLANK);
                if (ended_hyphen && label_chars > 0) flag(dnsc_pkg::ERR_TRAIL_HYP);
                if (label_flags[dnsc_pkg::PK_LEAD]) name_kinds[dnsc_pkg::ERR_LEAD_HYP] = 1'b1;
                if (label_flags[dnsc_pkg::PK_STAR]) name_kinds[dnsc_pkg::ERR_STAR_MIX] = 1'b1;
                if (label_flags[dnsc_pkg::PK_ILL]) begin
                    if (!name_kinds[dnsc_pkg::ERR_ILLEGAL]) name_bad = label_bad;
                    name_kinds[dnsc_pkg::ERR_ILLEGAL] = 1'b1;
                end
                name_problems = capped(name_problems, label_problems);
            end
            clear_label();
        endfunction

        function void note_item(logic op, logic [dnsc_pkg::CH_W-1:0] c, logic rec);
            t_name_verdict v;
            if (op == dnsc_pkg::OP_CHAR) begin
                if (name_chars == 0 && c == dnsc_pkg::CH_DOT) leading_dot = 1'b1;
                name_chars = capped(name_chars, 1);
                if (c == dnsc_pkg::CH_DOT) begin
                    close_label(rec);
                end else begin
                    lone_star = (label_chars == 0 && c == dnsc_pkg::CH_STAR);
                    if (c == dnsc_pkg::CH_HYPHEN) begin
                        if (label_chars == 0) begin
                            label_flags[dnsc_pkg::PK_LEAD] = 1'b1;
                            label_problems                 = capped(label_problems, 1);
                        end
                    end else if (!legal_char(c)) begin
                        if (rec && c == dnsc_pkg::CH_STAR) begin
                            label_flags[dnsc_pkg::PK_STAR] = 1'b1;
                        end else begin
                            if (!label_flags[dnsc_pkg::PK_ILL]) label_bad = c;
                            label_flags[dnsc_pkg::PK_ILL] = 1'b1;
                        end
                        label_problems = capped(label_problems, 1);
                    end
                    ended_hyphen = (c == dnsc_pkg::CH_HYPHEN);
                    label_chars  = capped(label_chars, 1);
                end
            end else begin
                v = '0;
                if (name_chars == 0) begin
                    v.kinds[dnsc_pkg::ERR_EMPTY] = 1'b1;
                    v.count                      = dnsc_pkg::CNT_W'(1);
                end else if (name_chars > dnsc_pkg::MAX_NAME) begin
                    v.kinds[dnsc_pkg::ERR_TOO_LONG] = 1'b1;
                    v.count                         = dnsc_pkg::CNT_W'(1);
                end else if (!(name_chars == 1 && leading_dot)) begin
                    if (label_chars > 0) flag(dnsc_pkg::ERR_NOT_ROOT);
                    v.kinds = name_kinds;
                    v.count = name_problems[dnsc_pkg::CNT_W-1:0];
                    v.bad   = name_bad;
                end
                v.ok = (v.count == 0);
                verdicts_due.push_back(v);
                clear_name();
            end
        endfunction

        function int unsigned outstanding();
            return verdicts_due.size();
        endfunction

        function void report(string field, int unsigned want, int unsigned got);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
        endfunction

        function void check_result(t_name_verdict got);
            t_name_verdict want;
            if (verdicts_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result, kinds %0h count %0d", $realtime,
                             got.kinds, got.count);
            end else begin
                want = verdicts_due.pop_front();
                if (got.kinds !== want.kinds) report("error_kinds", want.kinds, got.kinds);
                if (got.count !== want.count) report("problem_count", want.count, got.count);
                if (got.bad !== want.bad) report("first_bad_char", want.bad, got.bad);
                if (got.ok !== want.ok) report("name_ok", want.ok, got.ok);
            end
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n       = 1'b0;
    logic                         i_in_valid    = 1'b0;
    logic                         i_op          = dnsc_pkg::OP_CHAR;
    logic [dnsc_pkg::CH_W-1:0]    i_ch          = '0;
    logic                         i_record_mode = 1'b0;
    logic                         i_out_stall   = 1'b0;
    logic                         o_in_stall;
    logic                         o_out_valid;
    logic [dnsc_pkg::KINDS_W-1:0] o_error_kinds;
    logic [dnsc_pkg::CNT_W-1:0]   o_problem_count;
    logic [dnsc_pkg::CH_W-1:0]    o_first_bad_char;
    logic                         o_name_ok;

    t_verdict_board               board = new();
    logic [dnsc_pkg::CH_W-1:0]    spelled[$];
    bit                           tx_steady;
    int                           items_sent;
    int                           idle_cycles = 0;

    dns_name_syntax_checker_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_op             (i_op),
        .i_ch             (i_ch),
        .i_record_mode    (i_record_mode),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_error_kinds    (o_error_kinds),
        .o_problem_count  (o_problem_count),
        .o_first_bad_char (o_first_bad_char),
        .o_name_ok        (o_name_ok)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [dnsc_pkg::CH_W-1:0] any_alnum();
        int k;
        k = $urandom_range(0, 61);
        if (k < 10) return dnsc_pkg::CH_W'(8'h30 + k);
        if (k < 36) return dnsc_pkg::CH_W'(8'h41 + k - 10);
        return dnsc_pkg::CH_W'(8'h61 + k - 36);
    endfunction

    // clean label text, hyphens only inside
    function automatic void put_plain(int len);
        for (int i = 0; i < len; i++) begin
            if (i > 0 && i < len - 1 && $urandom_range(0, 5) == 0)
                spelled.push_back(dnsc_pkg::CH_HYPHEN);
            else
                spelled.push_back(any_alnum());
        end
    endfunction

    task automatic send_item(input logic op, input logic [dnsc_pkg::CH_W-1:0] c,
                             input logic rec);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_ch          <= c;
        i_record_mode <= rec;
        do @(posedge i_clk); while (o_in_stall);
        board.note_item(op, c, rec);
        items_sent++;
        @(negedge i_clk);
    endtask

    // record mode flips from flip_at on when flip_at is not negative
    task automatic send_name(input logic rec, input int flip_at);
        logic r;
        r = rec;
        foreach (spelled[i]) begin
            if (flip_at >= 0 && i == flip_at) r = ~rec;
            send_item(dnsc_pkg::OP_CHAR, spelled[i], r);
        end
        send_item(dnsc_pkg::OP_END, dnsc_pkg::CH_W'($urandom_range(0, 255)), r);
    endtask

    task automatic drain_pause();
        if (board.outstanding() != 0) begin
            i_in_valid <= 1'b0;
            while (board.outstanding() != 0) @(negedge i_clk);
        end
    endtask

    initial begin
        t_name_verdict got;
        int            hold;
        int            steady_left;
        steady_left = 0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (steady_left > 0) begin
                steady_left--;
                hold = 0;
            end else begin
                hold = $urandom_range(0, 16);
                if ($urandom_range(0, 9) == 0) steady_left = $urandom_range(2, 8);
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            got = {o_error_kinds, o_problem_count, o_first_bad_char, o_name_ok};
            board.check_result(got);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("dns_name_syntax_checker_unit verification failed");
            $finish;
        end
    end

    initial begin
        int shape;
        int kind;
        int len;
        int pos;
        int round;
        int flip_at;
        items_sent  = 0;
        tx_steady   = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        spelled = {};
        send_name(1'b0, -1);
        spelled = '{dnsc_pkg::CH_DOT};
        send_name(1'b0, -1);
        spelled = '{dnsc_pkg::CH_HYPHEN, dnsc_pkg::CH_DOT};
        send_name(1'b0, -1);
        spelled = '{dnsc_pkg::CH_STAR, dnsc_pkg::CH_DOT};
        send_name(1'b0, -1);
        send_name(1'b1, -1);
        spelled = '{8'h61, dnsc_pkg::CH_STAR, dnsc_pkg::CH_DOT};
        send_name(1'b1, -1);
        spelled = '{8'h00, 8'hFF, dnsc_pkg::CH_DOT};
        send_name(1'b0, -1);
        spelled = '{8'h61};
        send_name(1'b1, -1);
        drain_pause();

        round = 0;
        while (items_sent < NAME_ITEMS) begin
            spelled   = {};
            tx_steady = ($urandom_range(0, 3) == 0);
            if (round == 4 || round == 12) begin
                // longest legal name, then one character over
                for (int l = 0; l < 4; l++) begin
                    put_plain((l == 3 && round == 4) ? dnsc_pkg::MAX_LABEL - 1
                                                     : dnsc_pkg::MAX_LABEL);
                    spelled.push_back(dnsc_pkg::CH_DOT);
                end
            end else begin
                shape = $urandom_range(0, 99);
                if (shape < 6) begin
                    if (shape >= 3) spelled.push_back(dnsc_pkg::CH_DOT);
                end else if (shape < 12) begin
                    repeat ($urandom_range(1, 8))
                        spelled.push_back(dnsc_pkg::CH_W'($urandom_range(0, 255)));
                end else begin
                    repeat ($urandom_range(1, 4)) begin
                        kind = $urandom_range(0, 99);
                        len  = $urandom_range(1, 8);
                        if (kind < 60) begin
                            put_plain(len);
                        end else if (kind < 63) begin
                            put_plain($urandom_range(dnsc_pkg::MAX_LABEL - 1,
                                                     dnsc_pkg::MAX_LABEL + 2));
                        end else if (kind < 69) begin
                            spelled.push_back(dnsc_pkg::CH_STAR);
                        end else if (kind < 74) begin
                            spelled.push_back(dnsc_pkg::CH_HYPHEN);
                            put_plain(len);
                        end else if (kind < 79) begin
                            put_plain(len);
                            spelled.push_back(dnsc_pkg::CH_HYPHEN);
                        end else if (kind < 82) begin
                            spelled.push_back(dnsc_pkg::CH_HYPHEN);
                        end else if (kind < 88) begin
                            pos = spelled.size();
                            put_plain(len);
                            spelled.insert(pos + $urandom_range(0, len), dnsc_pkg::CH_STAR);
                        end else if (kind < 95) begin
                            pos = spelled.size();
                            put_plain(len);
                            spelled[pos + $urandom_range(0, len - 1)] =
                                dnsc_pkg::CH_W'($urandom_range(0, 255));
                        end
                        spelled.push_back(dnsc_pkg::CH_DOT);
                    end
                    if ($urandom_range(0, 7) == 0) put_plain($urandom_range(1, 4));
                end
            end
            flip_at = -1;
            if (spelled.size() > 0 && $urandom_range(0, 11) == 0)
                flip_at = $urandom_range(0, spelled.size() - 1);
            if ($urandom_range(0, 9) == 0) drain_pause();
            send_name($urandom_range(0, 1), flip_at);
            round++;
        end

        i_in_valid <= 1'b0;
        while (board.outstanding() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("dns_name_syntax_checker_unit verification clean");
        else
            $display("dns_name_syntax_checker_unit verification failed");
        $finish;
    end

endmodule
